[hw/rtl/md5_stream_hasher_macros.svh]
// ----------------------------------------------------------------------------
// MD5 stream hasher assertion macros
// Shared macros for the concurrent assertions of the hasher checker.
// ----------------------------------------------------------------------------
`ifndef MD5_STREAM_HASHER_MACROS_SVH
`define MD5_STREAM_HASHER_MACROS_SVH

// Checked on every clock edge outside reset.
`define MD5SH_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define MD5SH_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hw/rtl/md5sh_pkg.sv]
// ----------------------------------------------------------------------------
// MD5 stream hasher package
// Word types, state codes, round constants and round helper functions.
// ----------------------------------------------------------------------------
package md5sh_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       is_last;
   } req_word_type;

   typedef struct packed {
      logic [63:0] digest_half;
      logic        last_half;
   } rsp_word_type;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MARK  = 3'd1;
   localparam logic [2:0] ST_ZERO  = 3'd2;
   localparam logic [2:0] ST_LOAD  = 3'd3;
   localparam logic [2:0] ST_ROUND = 3'd4;
   localparam logic [2:0] ST_FIN   = 3'd5;
   localparam logic [2:0] ST_OUT0  = 3'd6;
   localparam logic [2:0] ST_OUT1  = 3'd7;

   localparam int          COUNT_WIDTH = 61;
   localparam logic [7:0]  PAD_MARK    = 8'h80;
   localparam logic [5:0]  LAST_POS    = 6'd63;
   localparam logic [2:0]  LEN_GROUP   = 3'd7;
   localparam logic [5:0]  LAST_ROUND  = 6'd63;

   localparam logic [3:0][31:0] CHAIN_INIT = {
      32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   function automatic logic [3:0] msg_index(input logic [5:0] rnd);
      logic [3:0] lo;
      logic [3:0] idx;
      lo = rnd[3:0];
      case (rnd[5:4])
         2'd0: begin
            idx = lo;
         end
         2'd1: begin
            idx = lo * 4'd5 + 4'd1;
         end
         2'd2: begin
            idx = lo * 4'd3 + 4'd5;
         end
         default: begin
            idx = lo * 4'd7;
         end
      endcase
      return idx;
   endfunction

   function automatic logic [4:0] shift_amt(input logic [5:0] rnd);
      logic [4:0] s;
      case ({rnd[5:4], rnd[1:0]})
         4'd0:  s = 5'd7;
         4'd1:  s = 5'd12;
         4'd2:  s = 5'd17;
         4'd3:  s = 5'd22;
         4'd4:  s = 5'd5;
         4'd5:  s = 5'd9;
         4'd6:  s = 5'd14;
         4'd7:  s = 5'd20;
         4'd8:  s = 5'd4;
         4'd9:  s = 5'd11;
         4'd10: s = 5'd16;
         4'd11: s = 5'd23;
         4'd12: s = 5'd6;
         4'd13: s = 5'd10;
         4'd14: s = 5'd15;
         default: s = 5'd21;
      endcase
      return s;
   endfunction

   function automatic logic [31:0] round_f(input logic [1:0] grp, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      case (grp)
         2'd0:    f = (b & c) | (~b & d);
         2'd1:    f = (d & b) | (~d & c);
         2'd2:    f = b ^ c ^ d;
         default: f = c ^ (b | ~d);
      endcase
      return f;
   endfunction

   function automatic logic [31:0] bswap32(input logic [31:0] x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

endpackage

[hw/rtl/md5sh_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module md5sh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/md5_stream_hasher.sv]
// ----------------------------------------------------------------------------
// MD5 stream hasher
// Packs message bytes into 64-byte blocks, compresses each block with one
// shared round unit and returns the 128-bit digest as two 64-bit halves.
//
//   Channel  Direction  Handshake             Word
//   req      in         req_valid/req_ready   data_byte, has_byte, is_last
//   rsp      out        rsp_valid/rsp_ready   digest_half, last_half
//
// A byte that neither fills a block nor ends the message leaves req_ready high.
// A full block is compressed as one load, 64 rounds of two phases each on
// the shared adder and rotator, and a fold into the chain words. Padding
// writes one byte per cycle into the block buffer. Reset is synchronous.
// req_ready is low while a full block is compressed and from an end marker
// until both digest halves are taken; rsp_ready low holds the digest.
// ----------------------------------------------------------------------------
module md5_stream_hasher import md5sh_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   logic [2:0]             state_ff, state_in;
   logic [3:0][31:0]       chain_ff, chain_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [31:0]            a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic [31:0]            sum_ff, sum_in;
   logic [5:0]             pos_ff, pos_in;
   logic [5:0]             rnd_ff, rnd_in;
   logic                   phase_ff, phase_in;
   logic                   last_ff, last_in;
   logic                   pad_ff, pad_in;
   logic                   extra_ff, extra_in;

   logic                   req_accept;
   logic                   wr_en;
   logic [5:0]             wr_pos;
   logic [7:0]             wr_byte;
   logic [3:0]             rd_addr;
   logic [31:0]            msg_word;
   logic [63:0]            len_bits;
   logic [63:0]            rot_wide;

   genvar lane;
   generate
      for (lane = 0; lane < 4; lane++) begin : g_lane
         md5sh_ram #(
            .WIDTH (8),
            .DEPTH (16)
         ) u_ram (
            .clock   (clock),
            .wr_en   (wr_en && (wr_pos[1:0] == 2'(lane))),
            .wr_addr (wr_pos[5:2]),
            .wr_data (wr_byte),
            .rd_addr (rd_addr),
            .rd_data (msg_word[lane*8 +: 8])
         );
      end
   endgenerate

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = (state_ff == ST_OUT0) || (state_ff == ST_OUT1);
   assign len_bits   = {count_ff, 3'b000};
   assign rot_wide   = {sum_ff, sum_ff} << shift_amt(rnd_ff);

   always_comb begin
      rsp_word.last_half = (state_ff == ST_OUT1);
      if (state_ff == ST_OUT1) begin
         rsp_word.digest_half = {bswap32(chain_ff[2]), bswap32(chain_ff[3])};
      end else begin
         rsp_word.digest_half = {bswap32(chain_ff[0]), bswap32(chain_ff[1])};
      end
   end

   always_comb begin
      state_in = state_ff;
      chain_in = chain_ff;
      count_in = count_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      sum_in   = sum_ff;
      pos_in   = pos_ff;
      rnd_in   = rnd_ff;
      phase_in = phase_ff;
      last_in  = last_ff;
      pad_in   = pad_ff;
      extra_in = extra_ff;
      wr_en    = 1'b0;
      wr_pos   = pos_ff;
      wr_byte  = '0;
      rd_addr  = msg_index(rnd_ff);
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               last_in = req_word.is_last;
               pad_in  = 1'b0;
               if (req_word.has_byte) begin
                  wr_en    = 1'b1;
                  wr_pos   = count_ff[5:0];
                  wr_byte  = req_word.data_byte;
                  count_in = count_ff + COUNT_WIDTH'(1);
                  if (count_ff[5:0] == LAST_POS) begin
                     state_in = ST_LOAD;
                  end else if (req_word.is_last) begin
                     pos_in   = count_ff[5:0] + 6'd1;
                     state_in = ST_MARK;
                  end
               end else if (req_word.is_last) begin
                  pos_in   = count_ff[5:0];
                  state_in = ST_MARK;
               end
            end
         end
         ST_MARK: begin
            wr_en    = 1'b1;
            wr_byte  = PAD_MARK;
            pad_in   = 1'b1;
            extra_in = (pos_ff[5:3] == LEN_GROUP);
            if (pos_ff == LAST_POS) begin
               state_in = ST_LOAD;
            end else begin
               pos_in   = pos_ff + 6'd1;
               state_in = ST_ZERO;
            end
         end
         ST_ZERO: begin
            wr_en = 1'b1;
            if ((pos_ff[5:3] == LEN_GROUP) && !extra_ff) begin
               wr_byte = len_bits[{pos_ff[2:0], 3'b000} +: 8];
            end
            if (pos_ff == LAST_POS) begin
               state_in = ST_LOAD;
            end else begin
               pos_in = pos_ff + 6'd1;
            end
         end
         ST_LOAD: begin
            rd_addr  = '0;
            a_in     = chain_ff[0];
            b_in     = chain_ff[1];
            c_in     = chain_ff[2];
            d_in     = chain_ff[3];
            rnd_in   = '0;
            phase_in = 1'b0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (!phase_ff) begin
               sum_in   = a_ff + round_f(rnd_ff[5:4], b_ff, c_ff, d_ff)
                        + ROUND_K[rnd_ff] + msg_word;
               phase_in = 1'b1;
            end else begin
               rd_addr  = msg_index(rnd_ff + 6'd1);
               a_in     = d_ff;
               d_in     = c_ff;
               c_in     = b_ff;
               b_in     = b_ff + rot_wide[63:32];
               rnd_in   = rnd_ff + 6'd1;
               phase_in = 1'b0;
               if (rnd_ff == LAST_ROUND) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            chain_in[0] = chain_ff[0] + a_ff;
            chain_in[1] = chain_ff[1] + b_ff;
            chain_in[2] = chain_ff[2] + c_ff;
            chain_in[3] = chain_ff[3] + d_ff;
            if (!pad_ff) begin
               if (last_ff) begin
                  pos_in   = '0;
                  state_in = ST_MARK;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (extra_ff) begin
               extra_in = 1'b0;
               pos_in   = '0;
               state_in = ST_ZERO;
            end else begin
               state_in = ST_OUT0;
            end
         end
         ST_OUT0: begin
            if (rsp_ready) begin
               state_in = ST_OUT1;
            end
         end
         ST_OUT1: begin
            if (rsp_ready) begin
               chain_in = CHAIN_INIT;
               count_in = '0;
               pad_in   = 1'b0;
               last_in  = 1'b0;
               extra_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chain_ff <= CHAIN_INIT;
         count_ff <= '0;
         last_ff  <= 1'b0;
         pad_ff   <= 1'b0;
         extra_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         chain_ff <= chain_in;
         count_ff <= count_in;
         last_ff  <= last_in;
         pad_ff   <= pad_in;
         extra_ff <= extra_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      c_ff     <= c_in;
      d_ff     <= d_in;
      sum_ff   <= sum_in;
      pos_ff   <= pos_in;
      rnd_ff   <= rnd_in;
      phase_ff <= phase_in;
   end

endmodule

[hw/rtl/md5sh_checker.sv]
// ----------------------------------------------------------------------------
// MD5 stream hasher checker
// Port-level assertions on digest delivery, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "md5_stream_hasher_macros.svh"

module md5sh_checker import md5sh_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input req_word_type req_word,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_word_type rsp_word
);

   // The input side stays closed while a digest is pending.
   `MD5SH_ASSERT(a_busy_on_rsp, rsp_valid |-> !req_ready, "input taken during digest")

   // The second half follows the first at once.
   `MD5SH_ASSERT(a_second_half, (rsp_valid && rsp_ready && !rsp_word.last_half) |=> (rsp_valid && rsp_word.last_half), "second digest half missing")

   // Nothing more is shown after the second half is taken.
   `MD5SH_ASSERT(a_end_of_digest, (rsp_valid && rsp_ready && rsp_word.last_half) |=> !rsp_valid, "extra digest word")

   // A word without an end marker never produces a digest next cycle.
   `MD5SH_ASSERT(a_no_early_digest, (req_valid && req_ready && !req_word.is_last) |=> !rsp_valid, "digest without end marker")

   // Reset leaves no digest pending.
   `MD5SH_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid, "digest pending after reset")

endmodule

bind md5_stream_hasher md5sh_checker u_md5sh_checker (.*);

[tb/md5_stream_hasher_tb.sv]
// ----------------------------------------------------------------------------
// MD5 stream hasher testbench
// Streams messages into the hasher one byte word at a time and checks both
// digest halves against a behavioral MD5 predictor kept in the testbench.
// Directed messages cover the empty message, single bytes, end markers
// without a byte and words that carry neither a byte nor an end. Random
// messages favor lengths near the padding limit and the block boundaries.
// The run steps through phases of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module md5_stream_hasher_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import md5sh_pkg::*;

   localparam int unsigned ROT_BY [16] = '{
      7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
   };
   localparam int LENGTH_EDGES [12] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
   localparam int PHASE_WORDS = 300;
   localparam int TAIL_CYCLES = 400;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;

   req_word_type pending_words [$];
   rsp_word_type expected_digests [$];
   int           words_queued = 0;
   int           words_taken = 0;
   int           error_count = 0;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;

   logic [31:0]  chain_st [4];
   logic [7:0]   msg_blk [64];
   logic [60:0]  msg_bytes;

   md5_stream_hasher uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic void restart_chain();
      for (int i = 0; i < 4; i++) begin
         chain_st[i] = CHAIN_INIT[i];
      end
      msg_bytes = '0;
   endfunction

   function automatic void md5_compress();
      logic [31:0] m [16];
      logic [31:0] a, b, c, d, f, t;
      int          g;
      int          grp;
      for (int r = 0; r < 16; r++) begin
         m[r] = {msg_blk[4*r+3], msg_blk[4*r+2], msg_blk[4*r+1], msg_blk[4*r]};
      end
      a = chain_st[0];
      b = chain_st[1];
      c = chain_st[2];
      d = chain_st[3];
      for (int r = 0; r < 64; r++) begin
         grp = r / 16;
         case (grp)
            0: begin
               f = (b & c) | (~b & d);
               g = r;
            end
            1: begin
               f = (d & b) | (~d & c);
               g = (5 * r + 1) % 16;
            end
            2: begin
               f = b ^ c ^ d;
               g = (3 * r + 5) % 16;
            end
            default: begin
               f = c ^ (b | ~d);
               g = (7 * r) % 16;
            end
         endcase
         t = d;
         d = c;
         c = b;
         b = b + rotl32(a + f + ROUND_K[r] + m[g], ROT_BY[grp * 4 + r % 4]);
         a = t;
      end
      chain_st[0] = chain_st[0] + a;
      chain_st[1] = chain_st[1] + b;
      chain_st[2] = chain_st[2] + c;
      chain_st[3] = chain_st[3] + d;
   endfunction

   function automatic void predict_word(input req_word_type w);
      int           fill;
      int           byte_no;
      logic [63:0]  bit_len;
      logic [31:0]  chain_word;
      rsp_word_type half;
      if (w.has_byte) begin
         fill = int'(msg_bytes[5:0]);
         msg_blk[fill] = w.data_byte;
         msg_bytes = msg_bytes + 61'd1;
         if (fill == 63) begin
            md5_compress();
         end
      end
      if (!w.is_last) begin
         return;
      end
      fill = int'(msg_bytes[5:0]);
      bit_len = {msg_bytes, 3'b000};
      msg_blk[fill] = 8'h80;
      for (int i = fill + 1; i < 64; i++) begin
         msg_blk[i] = 8'h00;
      end
      if (fill >= 56) begin
         md5_compress();
         for (int i = 0; i < 56; i++) begin
            msg_blk[i] = 8'h00;
         end
      end
      for (int i = 0; i < 8; i++) begin
         msg_blk[56+i] = bit_len[8*i +: 8];
      end
      md5_compress();
      for (int k = 0; k < 2; k++) begin
         half.digest_half = '0;
         half.last_half = (k == 1);
         for (int j = 0; j < 8; j++) begin
            byte_no = 8 * k + j;
            chain_word = chain_st[byte_no / 4];
            half.digest_half = {half.digest_half[55:0], chain_word[8*(byte_no%4) +: 8]};
         end
         expected_digests.insert(expected_digests.size(), half);
      end
      restart_chain();
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_word <= '0;
      end else begin
         if (req_valid && req_ready) begin
            predict_word(req_word);
            words_taken++;
         end
         if (!req_valid || req_ready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_word <= pending_words.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_digests.size() == 0) begin
               $error("unexpected digest word: digest_half %h, last_half %b",
                      rsp_word.digest_half, rsp_word.last_half);
               error_count++;
            end else begin
               if (rsp_word.digest_half !== expected_digests[0].digest_half) begin
                  $error("digest_half: expected %h, got %h",
                         expected_digests[0].digest_half, rsp_word.digest_half);
                  error_count++;
               end
               if (rsp_word.last_half !== expected_digests[0].last_half) begin
                  $error("last_half: expected %b, got %b",
                         expected_digests[0].last_half, rsp_word.last_half);
                  error_count++;
               end
               void'(expected_digests.pop_front());
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic queue_word(input logic [7:0] b, input logic hb, input logic last);
      req_word_type w;
      w.data_byte = b;
      w.has_byte = hb;
      w.is_last = last;
      pending_words.insert(pending_words.size(), w);
      words_queued++;
   endtask

   task automatic queue_message(input int len, inout int count);
      bit split_end;
      split_end = (len == 0) || ($urandom_range(1) == 1);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(19) == 0) begin
            queue_word(8'($urandom_range(255)), 1'b0, 1'b0);
         end
         queue_word(8'($urandom_range(255)), 1'b1, !split_end && (i == len - 1));
         count++;
      end
      if (split_end) begin
         queue_word(8'($urandom_range(255)), 1'b0, 1'b1);
         count++;
      end
   endtask

   task automatic run_random_phase(input int idle_pct, input int stall_pct);
      int count;
      int len;
      count = 0;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      while (count < PHASE_WORDS) begin
         if ($urandom_range(3) == 0) begin
            len = LENGTH_EDGES[$urandom_range(11)];
         end else begin
            len = $urandom_range(40);
         end
         queue_message(len, count);
      end
      while (words_taken != words_queued || expected_digests.size() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      restart_chain();
      for (int i = 0; i < 64; i++) begin
         msg_blk[i] = 8'h00;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      queue_word(8'hff, 1'b0, 1'b0);
      queue_word(8'h00, 1'b0, 1'b1);
      queue_word(8'h00, 1'b1, 1'b1);
      queue_word(8'hff, 1'b1, 1'b0);
      queue_word(8'h5a, 1'b0, 1'b1);
      queue_word(8'h61, 1'b1, 1'b0);
      queue_word(8'h62, 1'b1, 1'b0);
      queue_word(8'h63, 1'b1, 1'b1);
      queue_word(8'h80, 1'b1, 1'b0);
      queue_word(8'hff, 1'b0, 1'b0);
      queue_word(8'h7f, 1'b1, 1'b0);
      queue_word(8'hff, 1'b0, 1'b1);

      run_random_phase(0, 0);
      run_random_phase(61, 0);
      run_random_phase(0, 61);
      run_random_phase(37, 37);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_digests.size() != 0) begin
         $error("%0d digest words never arrived", expected_digests.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("md5_stream_hasher_tb: done, clean");
      end else begin
         $display("md5_stream_hasher_tb: done, errors");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("md5_stream_hasher_tb: done, errors");
      $finish;
   end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/md5sh_pkg.sv
hw/rtl/md5sh_ram.sv
hw/rtl/md5_stream_hasher.sv
hw/rtl/md5sh_checker.sv
tb/md5_stream_hasher_tb.sv
